FILE: sv/gbta_pkg.sv
// Shared types, constants and helper functions of the box-to-track association block.
package gbta_pkg;

   // Size of the track table.
   localparam int NUM_TRACKS = 16;
   localparam int IDX_W      = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_LOST_TIME  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_EXTRA_TIME = 1'b1;
   localparam logic [31:0] LOST_TIME_RESET  = 32'd2000;
   localparam logic [31:0] EXTRA_TIME_RESET = 32'd10000;

   // Fixed-point constants: minimum height 0.01, same-id bonus 2.0, reciprocal of five.
   localparam logic [15:0] MIN_HEIGHT  = 16'd655;
   localparam logic [19:0] SAME_BONUS  = 20'd131072;
   localparam logic [19:0] RECIP_FIVE  = 20'd419431;
   localparam int          RECIP_SHIFT = 21;
   localparam logic [39:0] DIST_LIMIT  = 40'h04_0000_0000;
   localparam logic [16:0] MOVE_CAP    = 17'd65536;

   // Last iteration indexes of the shared divide and square-root unit.
   localparam int ITER_W     = 5;
   localparam int DIV_LAST   = 16;
   localparam int SQRT_LAST  = 17;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AREA,
      ST_LOAD,
      ST_MUL,
      ST_TEST,
      ST_ITER,
      ST_SCORE,
      ST_DECIDE,
      ST_MOVE,
      ST_ACT,
      ST_FINISH,
      ST_EMIT
   } state_type;

   // Extent of an edge pair, zero when the pair is inverted.
   function automatic logic [15:0] span16(input logic [15:0] lo, input logic [15:0] hi);
      span16 = (hi > lo) ? (hi - lo) : 16'd0;
   endfunction

   // Box height with a floor of 0.01.
   function automatic logic [15:0] height16(input logic [15:0] top, input logic [15:0] bot);
      logic [15:0] h;
      h = span16(top, bot);
      height16 = (h > MIN_HEIGHT) ? h : MIN_HEIGHT;
   endfunction

   // Absolute difference of two 17-bit values.
   function automatic logic [16:0] absdiff17(input logic [16:0] a, input logic [16:0] b);
      absdiff17 = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

FILE: sv/greedy_box_track_association.sv
// Top level: track table and sequencer for greedy box-to-track association.
// A frame-start item is taken while idle; expiry of idle tracks happens at the accepting edge.
// A detection scans each table entry, which is skipped, fails the gate or is scored; a
// matched track is then updated through the shared 18-step divide and square-root unit.
// The result then waits in the emit state while the output stalls.
// Synchronous active-high reset clears all valid and matched marks, the frame time and next id.
module greedy_box_track_association import gbta_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [31:0]          req_time_ms,
   input  logic [15:0]          req_box_left,
   input  logic [15:0]          req_box_top,
   input  logic [15:0]          req_box_right,
   input  logic [15:0]          req_box_bottom,
   input  logic [31:0]          req_det_id,
   input  logic [15:0]          req_confidence,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_assigned_track,
   output logic                 rsp_new_track,
   output logic                 rsp_table_full,
   output logic [15:0]          rsp_activity_level,
   output logic [15:0]          rsp_sighting_count,
   output logic [15:0]          rsp_best_score,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   // Sequencer state.
   state_type state_ff, state_in;

   // Configuration and global state.
   logic [31:0] lost_ff, extra_ff, frame_time_ff, next_id_ff;

   // Track table.
   logic [NUM_TRACKS-1:0] valid_ff, matched_ff;
   logic [31:0] tid_ff [NUM_TRACKS];
   logic [31:0] src_ff [NUM_TRACKS];
   logic [31:0] seen_ff [NUM_TRACKS];
   logic [15:0] bl_ff [NUM_TRACKS];
   logic [15:0] bt_ff [NUM_TRACKS];
   logic [15:0] br_ff [NUM_TRACKS];
   logic [15:0] bb_ff [NUM_TRACKS];
   logic [15:0] pcx_ff [NUM_TRACKS];
   logic [15:0] pcy_ff [NUM_TRACKS];
   logic [15:0] act_ff [NUM_TRACKS];
   logic [15:0] sight_ff [NUM_TRACKS];
   logic [15:0] bestp_ff [NUM_TRACKS];

   // Latched detection item.
   logic [15:0] l_ff, t_ff, r_ff, b_ff, ps_ff;
   logic [31:0] sid_ff;

   // Scan and datapath registers.
   logic [IDX_W-1:0] idx_ff, sel_ff;
   logic [1:0]  msel_ff;
   logic [15:0] iw_ff, ih_ff, ow_ff, oh_ff;
   logic [16:0] adx_ff, ady_ff;
   logic        same_ff, hok_ff;
   logic [31:0] an_ff, inter_ff, ao_ff;
   logic [33:0] dx2_ff, dy2_ff;
   logic [ITER_W-1:0] cnt_ff;
   logic [33:0] dvr_ff, drem_ff;
   logic [16:0] q_ff;
   logic        div_on_ff;
   logic [35:0] sq_src_ff;
   logic [20:0] sq_rem_ff;
   logic [17:0] sq_root_ff;
   logic signed [19:0] best_ff;
   logic [31:0] best_tid_ff;
   logic        found_ff, mv_ff, opened_ff, full_ff;
   logic [39:0] pact_ff;

   // Result register.
   logic        rsp_valid_ff, rsp_new_ff, rsp_full_ff;
   logic [31:0] rsp_tid_ff;
   logic [15:0] rsp_act_ff, rsp_sight_ff, rsp_best_ff;

   // Handshake and strobes.
   logic req_take, take_frame, take_box, emit_go, is_last;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_valid && req_ready;
   assign take_frame = req_take && !req_mode;
   assign take_box   = req_take && req_mode;
   assign emit_go    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign is_last    = (idx_ff == IDX_W'(NUM_TRACKS - 1));

   // Geometry of the new box.
   logic [15:0] nw, nh, hn;
   logic [16:0] nsx, nsy;
   logic [15:0] ncx, ncy;
   assign nw  = span16(l_ff, r_ff);
   assign nh  = span16(t_ff, b_ff);
   assign hn  = height16(t_ff, b_ff);
   assign nsx = {1'b0, l_ff} + {1'b0, r_ff};
   assign nsy = {1'b0, t_ff} + {1'b0, b_ff};
   assign ncx = nsx[16:1];
   assign ncy = nsy[16:1];

   // Geometry of the entry under the scan index.
   logic [15:0] ol, ot, orr, ob, ho;
   logic [16:0] osx, osy;
   logic [31:0] age;
   logic        skip;
   assign ol   = bl_ff[idx_ff];
   assign ot   = bt_ff[idx_ff];
   assign orr  = br_ff[idx_ff];
   assign ob   = bb_ff[idx_ff];
   assign ho   = height16(ot, ob);
   assign osx  = {1'b0, ol} + {1'b0, orr};
   assign osy  = {1'b0, ot} + {1'b0, ob};
   assign age  = frame_time_ff - seen_ff[idx_ff];
   assign skip = !valid_ff[idx_ff] || matched_ff[idx_ff] || (age > lost_ff);

   // Gate test on the four products.
   logic [33:0] uni;
   logic [34:0] d2;
   logic        spatial, qualify;
   assign uni = {2'b0, ao_ff} + {2'b0, an_ff} - {2'b0, inter_ff};
   assign d2  = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign spatial = ((uni != 34'd0) &&
                     ((37'(inter_ff) * 37'd25) >= (37'(uni) * 37'd3))) ||
                    (((40'(d2) * 40'd25) <= DIST_LIMIT) && hok_ff);
   assign qualify = same_ff || spatial;

   // Shared multiplier.
   logic [16:0] mul_a, mul_b;
   logic [33:0] prod;
   always_comb begin
      mul_a = 17'd0;
      mul_b = 17'd0;
      case (state_ff)
         ST_AREA: begin
            mul_a = {1'b0, nw};
            mul_b = {1'b0, nh};
         end
         ST_MUL: begin
            case (msel_ff)
               2'd0: begin mul_a = {1'b0, iw_ff}; mul_b = {1'b0, ih_ff}; end
               2'd1: begin mul_a = {1'b0, ow_ff}; mul_b = {1'b0, oh_ff}; end
               2'd2: begin mul_a = adx_ff; mul_b = adx_ff; end
               default: begin mul_a = ady_ff; mul_b = ady_ff; end
            endcase
         end
         ST_MOVE: begin
            if (msel_ff == 2'd0) begin
               mul_a = absdiff17({1'b0, ncx}, {1'b0, pcx_ff[idx_ff]});
            end else begin
               mul_a = absdiff17({1'b0, ncy}, {1'b0, pcy_ff[idx_ff]});
            end
            mul_b = mul_a;
         end
         default: begin
            mul_a = 17'd0;
            mul_b = 17'd0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   // One step of the restoring divider and of the bit-pair square root.
   logic [33:0] div_sh;
   logic [22:0] sq_sh;
   logic [22:0] sq_trial;
   assign div_sh   = (cnt_ff == '0) ? drem_ff : {drem_ff[32:0], 1'b0};
   assign sq_sh    = {sq_rem_ff, sq_src_ff[35:34]};
   assign sq_trial = {3'b0, sq_root_ff, 2'b01};

   // Candidate score.
   logic signed [19:0] score;
   assign score = $signed(same_ff ? SAME_BONUS : 20'd0) + $signed({3'b0, q_ff})
                - $signed({4'b0, sq_root_ff[17:2]});

   // Lowest free entry.
   logic [IDX_W-1:0] slot;
   logic             free_any;
   always_comb begin
      slot     = '0;
      free_any = 1'b0;
      for (int i = NUM_TRACKS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            slot     = IDX_W'(i);
            free_any = 1'b1;
         end
      end
   end

   // Activity update values.
   logic [16:0] m8;
   logic [18:0] act_sum;
   logic [18:0] act_new;
   assign m8      = (sq_root_ff > 18'd8192) ? MOVE_CAP : {sq_root_ff[13:0], 3'b000};
   assign act_sum = {1'b0, act_ff[idx_ff], 2'b00} + {2'b0, m8};
   assign act_new = pact_ff[RECIP_SHIFT+18:RECIP_SHIFT];

   // Expiry limit, summed in 33 bits.
   logic [32:0] limit;
   assign limit = {1'b0, lost_ff} + {1'b0, extra_ff};

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (take_box) state_in = ST_AREA;
         ST_AREA:   state_in = ST_LOAD;
         ST_LOAD: begin
            if (!skip) state_in = ST_MUL;
            else if (is_last) state_in = ST_DECIDE;
         end
         ST_MUL:    if (msel_ff == 2'd3) state_in = ST_TEST;
         ST_TEST: begin
            if (qualify) state_in = ST_ITER;
            else state_in = is_last ? ST_DECIDE : ST_LOAD;
         end
         ST_ITER: begin
            if (cnt_ff == ITER_W'(SQRT_LAST)) state_in = mv_ff ? ST_ACT : ST_SCORE;
         end
         ST_SCORE:  state_in = is_last ? ST_DECIDE : ST_LOAD;
         ST_DECIDE: state_in = found_ff ? ST_MOVE : ST_EMIT;
         ST_MOVE:   if (msel_ff == 2'd1) state_in = ST_ITER;
         ST_ACT:    state_in = ST_FINISH;
         ST_FINISH: state_in = ST_EMIT;
         ST_EMIT:   if (emit_go) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers, frame time, next id and the valid and matched marks.
   always_ff @(posedge clock) begin
      if (reset) begin
         lost_ff       <= LOST_TIME_RESET;
         extra_ff      <= EXTRA_TIME_RESET;
         frame_time_ff <= 32'd0;
         next_id_ff    <= 32'd0;
         valid_ff      <= '0;
         matched_ff    <= '0;
      end else begin
         if (csr_we && csr_index == REG_LOST_TIME) lost_ff <= csr_wdata;
         if (csr_we && csr_index == REG_EXTRA_TIME) extra_ff <= csr_wdata;
         if (take_frame) begin
            frame_time_ff <= req_time_ms;
            matched_ff    <= '0;
            for (int i = 0; i < NUM_TRACKS; i++) begin
               if (valid_ff[i] && ({1'b0, req_time_ms - seen_ff[i]} >= limit)) begin
                  valid_ff[i] <= 1'b0;
               end
            end
         end
         if (state_ff == ST_DECIDE && !found_ff && free_any) begin
            next_id_ff       <= next_id_ff + 32'd1;
            valid_ff[slot]   <= 1'b1;
            matched_ff[slot] <= 1'b1;
         end
         if (state_ff == ST_FINISH) matched_ff[idx_ff] <= 1'b1;
      end
   end

   // Entry payload writes for a new track and for a matched track.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE && !found_ff && free_any) begin
         tid_ff[slot]   <= next_id_ff + 32'd1;
         act_ff[slot]   <= 16'd0;
         sight_ff[slot] <= 16'd1;
         bestp_ff[slot] <= ps_ff;
         src_ff[slot]   <= sid_ff;
         bl_ff[slot]    <= l_ff;
         bt_ff[slot]    <= t_ff;
         br_ff[slot]    <= r_ff;
         bb_ff[slot]    <= b_ff;
         pcx_ff[slot]   <= ncx;
         pcy_ff[slot]   <= ncy;
         seen_ff[slot]  <= frame_time_ff;
      end
      if (state_ff == ST_FINISH) begin
         act_ff[idx_ff] <= (act_new > 19'd65535) ? 16'hFFFF : act_new[15:0];
         if (sight_ff[idx_ff] != 16'hFFFF) sight_ff[idx_ff] <= sight_ff[idx_ff] + 16'd1;
         if (ps_ff > bestp_ff[idx_ff]) bestp_ff[idx_ff] <= ps_ff;
         src_ff[idx_ff]  <= sid_ff;
         bl_ff[idx_ff]   <= l_ff;
         bt_ff[idx_ff]   <= t_ff;
         br_ff[idx_ff]   <= r_ff;
         bb_ff[idx_ff]   <= b_ff;
         pcx_ff[idx_ff]  <= ncx;
         pcy_ff[idx_ff]  <= ncy;
         seen_ff[idx_ff] <= frame_time_ff;
      end
   end

   // Datapath registers stepped by the sequencer.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (take_box) begin
               l_ff      <= req_box_left;
               t_ff      <= req_box_top;
               r_ff      <= req_box_right;
               b_ff      <= req_box_bottom;
               sid_ff    <= req_det_id;
               ps_ff     <= req_confidence;
               idx_ff    <= '0;
               found_ff  <= 1'b0;
               mv_ff     <= 1'b0;
               opened_ff <= 1'b0;
               full_ff   <= 1'b0;
            end
         end
         ST_AREA: an_ff <= prod[31:0];
         ST_LOAD: begin
            iw_ff   <= span16((l_ff > ol) ? l_ff : ol, (r_ff < orr) ? r_ff : orr);
            ih_ff   <= span16((t_ff > ot) ? t_ff : ot, (b_ff < ob) ? b_ff : ob);
            ow_ff   <= span16(ol, orr);
            oh_ff   <= span16(ot, ob);
            adx_ff  <= absdiff17(osx, nsx);
            ady_ff  <= absdiff17(osy, nsy);
            same_ff <= (src_ff[idx_ff] == sid_ff);
            hok_ff  <= ({1'b0, hn, 1'b0} >= {2'b0, ho}) && ({2'b0, hn} <= {1'b0, ho, 1'b0});
            msel_ff <= 2'd0;
            if (skip && !is_last) idx_ff <= idx_ff + IDX_W'(1);
         end
         ST_MUL: begin
            case (msel_ff)
               2'd0: inter_ff <= prod[31:0];
               2'd1: ao_ff    <= prod[31:0];
               2'd2: dx2_ff   <= prod;
               default: dy2_ff <= prod;
            endcase
            msel_ff <= msel_ff + 2'd1;
         end
         ST_TEST: begin
            dvr_ff     <= uni;
            drem_ff    <= {2'b0, inter_ff};
            q_ff       <= 17'd0;
            div_on_ff  <= (uni != 34'd0);
            sq_src_ff  <= {1'b0, d2};
            sq_rem_ff  <= 21'd0;
            sq_root_ff <= 18'd0;
            cnt_ff     <= '0;
            if (!qualify && !is_last) idx_ff <= idx_ff + IDX_W'(1);
         end
         ST_ITER: begin
            cnt_ff <= cnt_ff + ITER_W'(1);
            if (div_on_ff && cnt_ff <= ITER_W'(DIV_LAST)) begin
               if (div_sh >= dvr_ff) begin
                  drem_ff <= div_sh - dvr_ff;
                  q_ff    <= {q_ff[15:0], 1'b1};
               end else begin
                  drem_ff <= div_sh;
                  q_ff    <= {q_ff[15:0], 1'b0};
               end
            end
            sq_src_ff <= {sq_src_ff[33:0], 2'b00};
            if (sq_sh >= sq_trial) begin
               sq_rem_ff  <= 21'(sq_sh - sq_trial);
               sq_root_ff <= {sq_root_ff[16:0], 1'b1};
            end else begin
               sq_rem_ff  <= sq_sh[20:0];
               sq_root_ff <= {sq_root_ff[16:0], 1'b0};
            end
         end
         ST_SCORE: begin
            if (!found_ff || score > best_ff ||
                (score == best_ff && tid_ff[idx_ff] < best_tid_ff)) begin
               best_ff     <= score;
               best_tid_ff <= tid_ff[idx_ff];
               sel_ff      <= idx_ff;
               found_ff    <= 1'b1;
            end
            if (!is_last) idx_ff <= idx_ff + IDX_W'(1);
         end
         ST_DECIDE: begin
            msel_ff <= 2'd0;
            if (found_ff) begin
               idx_ff <= sel_ff;
               mv_ff  <= 1'b1;
            end else if (free_any) begin
               idx_ff    <= slot;
               opened_ff <= 1'b1;
            end else begin
               full_ff <= 1'b1;
            end
         end
         ST_MOVE: begin
            msel_ff <= msel_ff + 2'd1;
            if (msel_ff == 2'd0) begin
               dx2_ff <= prod;
            end else begin
               sq_src_ff  <= {2'b0, dx2_ff} + {2'b0, prod};
               sq_rem_ff  <= 21'd0;
               sq_root_ff <= 18'd0;
               div_on_ff  <= 1'b0;
               cnt_ff     <= '0;
            end
         end
         ST_ACT: pact_ff <= 40'(act_sum) * 40'(RECIP_FIVE);
         default: begin
         end
      endcase
   end

   // Result register: table entry or zeros if full, loaded once no earlier item waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_go) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_full_ff  <= full_ff;
         rsp_new_ff   <= opened_ff;
         rsp_tid_ff   <= full_ff ? 32'd0 : tid_ff[idx_ff];
         rsp_act_ff   <= full_ff ? 16'd0 : act_ff[idx_ff];
         rsp_sight_ff <= full_ff ? 16'd0 : sight_ff[idx_ff];
         rsp_best_ff  <= full_ff ? 16'd0 : bestp_ff[idx_ff];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_assigned_track = rsp_tid_ff;
   assign rsp_new_track      = rsp_new_ff;
   assign rsp_table_full     = rsp_full_ff;
   assign rsp_activity_level = rsp_act_ff;
   assign rsp_sighting_count = rsp_sight_ff;
   assign rsp_best_score     = rsp_best_ff;

endmodule

FILE: sv/gbta_checker.sv
// Port-level checker for the association block, bound to the top level.
module gbta_checker import gbta_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_assigned_track,
   input logic        rsp_new_track,
   input logic        rsp_table_full,
   input logic [15:0] rsp_activity_level,
   input logic [15:0] rsp_sighting_count
);

   // A detection item keeps the block busy for the next cycle.
   a_busy_after_box: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode |=> !req_ready)
      else $error("block ready right after taking a detection item");

   // A full table reports no track and no new track.
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_assigned_track == 32'd0 && !rsp_new_track)
      else $error("table-full item carries a track");

   // A new track starts with one sighting and no activity.
   a_new_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_track |-> rsp_sighting_count == 16'd1 &&
      rsp_activity_level == 16'd0 && !rsp_table_full)
      else $error("new track item with wrong start values");

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_assigned_track))
      else $error("result item changed while stalled");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind greedy_box_track_association gbta_checker u_gbta_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_mode           (req_mode),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_assigned_track (rsp_assigned_track),
   .rsp_new_track      (rsp_new_track),
   .rsp_table_full     (rsp_table_full),
   .rsp_activity_level (rsp_activity_level),
   .rsp_sighting_count (rsp_sighting_count)
);

FILE: verif/greedy_box_track_association_test.sv
// Self-checking testbench for the greedy box-to-track association block.
module greedy_box_track_association_test;
   timeunit 1ns;
   timeprecision 1ps;
   import gbta_pkg::*;

   typedef struct {
      logic        mode;
      logic [31:0] time_ms;
      logic [15:0] left, top, right, bottom;
      logic [31:0] det_id;
      logic [15:0] confidence;
   } box_item_type;

   typedef struct {
      logic [31:0] track;
      logic        new_track;
      logic        full;
      logic [15:0] activity;
      logic [15:0] sightings;
      logic [15:0] best;
   } assoc_result_type;

   // Keeps its own copy of the track table and the queue of predicted associations.
   class assoc_scoreboard;
      logic [31:0] lost_time, extra_time;
      bit          ent_valid[NUM_TRACKS];
      bit          ent_matched[NUM_TRACKS];
      logic [31:0] ent_id[NUM_TRACKS], ent_sid[NUM_TRACKS], ent_seen[NUM_TRACKS];
      logic [15:0] ent_l[NUM_TRACKS], ent_t[NUM_TRACKS], ent_r[NUM_TRACKS], ent_b[NUM_TRACKS];
      logic [15:0] ent_cx[NUM_TRACKS], ent_cy[NUM_TRACKS];
      logic [15:0] ent_act[NUM_TRACKS], ent_cnt[NUM_TRACKS], ent_best[NUM_TRACKS];
      logic [31:0] frame_now, last_id;
      assoc_result_type pending[$];
      int errors, checked, opened, fulls, frames;

      function new();
         lost_time = LOST_TIME_RESET;
         extra_time = EXTRA_TIME_RESET;
         frame_now = 0;
         last_id = 0;
         foreach (ent_valid[i]) begin
            ent_valid[i] = 0;
            ent_matched[i] = 0;
         end
      endfunction

      function void set_config(logic [31:0] lost, logic [31:0] extra);
         lost_time = lost;
         extra_time = extra;
      endfunction

      function longint ext(longint lo, longint hi);
         return (hi > lo) ? hi - lo : 0;
      endfunction

      function longint root(longint v);
         longint r, bit_v;
         r = 0;
         bit_v = 64'sh4000_0000_0000_0000;
         while (bit_v > v) bit_v = bit_v >> 2;
         while (bit_v != 0) begin
            if (v >= r + bit_v) begin
               v = v - (r + bit_v);
               r = (r >> 1) + bit_v;
            end else begin
               r = r >> 1;
            end
            bit_v = bit_v >> 2;
         end
         return r;
      endfunction

      function longint hgt(longint t, longint b);
         longint h;
         h = ext(t, b);
         return (h > 655) ? h : 655;
      endfunction

      // Predict the effect of one accepted item.
      function void note_input(box_item_type it);
         longint l, t, r, b, ol, ot, orr, ob, inter, uni, iou, dsx, dsy, d2, hn, ho;
         longint score, top_score, ncx, ncy, dx, dy, m8, a;
         longint limit;
         bit same, spatial;
         int sel, slot;
         assoc_result_type res;
         l = it.left; t = it.top; r = it.right; b = it.bottom;
         if (it.mode == 1'b0) begin
            frames++;
            limit = longint'(lost_time) + longint'(extra_time);
            frame_now = it.time_ms;
            foreach (ent_valid[i]) begin
               ent_matched[i] = 0;
               if (ent_valid[i] && longint'(32'(frame_now - ent_seen[i])) >= limit)
                  ent_valid[i] = 0;
            end
            return;
         end
         sel = -1;
         slot = -1;
         top_score = 0;
         for (int i = 0; i < NUM_TRACKS; i++) begin
            if (!ent_valid[i] || ent_matched[i]) continue;
            if (32'(frame_now - ent_seen[i]) > lost_time) continue;
            ol = ent_l[i]; ot = ent_t[i]; orr = ent_r[i]; ob = ent_b[i];
            inter = ext((l > ol) ? l : ol, (r < orr) ? r : orr) *
                    ext((t > ot) ? t : ot, (b < ob) ? b : ob);
            uni = ext(ol, orr) * ext(ot, ob) + ext(l, r) * ext(t, b) - inter;
            iou = (uni > 0) ? (inter <<< 16) / uni : 0;
            dsx = (ol + orr) - (l + r);
            dsy = (ot + ob) - (t + b);
            d2 = dsx * dsx + dsy * dsy;
            hn = hgt(t, b);
            ho = hgt(ot, ob);
            same = (ent_sid[i] == it.det_id);
            spatial = (uni > 0 && 25 * inter >= 3 * uni) ||
                      (25 * d2 <= 64'sh4_0000_0000 && 2 * hn >= ho && hn <= 2 * ho);
            if (!same && !spatial) continue;
            score = (same ? 131072 : 0) + iou - (root(d2) >> 2);
            if (sel < 0 || score > top_score ||
                (score == top_score && ent_id[i] < ent_id[sel])) begin
               top_score = score;
               sel = i;
            end
         end
         ncx = (l + r) >> 1;
         ncy = (t + b) >> 1;
         if (sel < 0) begin
            for (int i = 0; i < NUM_TRACKS; i++)
               if (!ent_valid[i] && slot < 0) slot = i;
            if (slot < 0) begin
               fulls++;
               res = '{32'd0, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0};
               pending = {pending, res};
               return;
            end
            opened++;
            last_id = last_id + 1;
            ent_valid[slot] = 1;
            ent_id[slot] = last_id;
            ent_act[slot] = 0;
            ent_cnt[slot] = 1;
            ent_best[slot] = it.confidence;
            sel = slot;
         end else begin
            dx = (ncx > ent_cx[sel]) ? ncx - ent_cx[sel] : ent_cx[sel] - ncx;
            dy = (ncy > ent_cy[sel]) ? ncy - ent_cy[sel] : ent_cy[sel] - ncy;
            m8 = root(dx * dx + dy * dy) * 8;
            if (m8 > 65536) m8 = 65536;
            a = (4 * longint'(ent_act[sel]) + m8) / 5;
            ent_act[sel] = (a > 65535) ? 16'hFFFF : 16'(a);
            if (ent_cnt[sel] != 16'hFFFF) ent_cnt[sel]++;
            if (it.confidence > ent_best[sel]) ent_best[sel] = it.confidence;
         end
         ent_sid[sel] = it.det_id;
         ent_l[sel] = it.left; ent_t[sel] = it.top;
         ent_r[sel] = it.right; ent_b[sel] = it.bottom;
         ent_cx[sel] = 16'(ncx);
         ent_cy[sel] = 16'(ncy);
         ent_seen[sel] = frame_now;
         ent_matched[sel] = 1;
         res = '{ent_id[sel], (slot >= 0), 1'b0, ent_act[sel], ent_cnt[sel], ent_best[sel]};
         pending = {pending, res};
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
         errors++;
      endtask

      // Compare one accepted result with the oldest prediction.
      task check_result(assoc_result_type got);
         assoc_result_type want;
         if (pending.size() == 0) begin
            report("unexpected result, track", got.track, 0);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.track !== want.track) report("assigned_track", got.track, want.track);
         if (got.new_track !== want.new_track) report("new_track", got.new_track, want.new_track);
         if (got.full !== want.full) report("table_full", got.full, want.full);
         if (got.activity !== want.activity) report("activity_level", got.activity, want.activity);
         if (got.sightings !== want.sightings)
            report("sighting_count", got.sightings, want.sightings);
         if (got.best !== want.best) report("best_score", got.best, want.best);
      endtask
   endclass

   logic        clock, reset;
   logic        req_valid, req_ready, req_mode;
   logic [31:0] req_time_ms, req_det_id;
   logic [15:0] req_box_left, req_box_top, req_box_right, req_box_bottom, req_confidence;
   logic        rsp_valid, rsp_ready, rsp_new_track, rsp_table_full;
   logic [31:0] rsp_assigned_track;
   logic [15:0] rsp_activity_level, rsp_sighting_count, rsp_best_score;
   logic        csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   greedy_box_track_association dut (.*);

   assoc_scoreboard tracker = new();

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   initial begin
      #40ms;
      $display("TB_ERROR");
      $finish;
   end

   // Monitors for accepted items and results.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         tracker.note_input('{req_mode, req_time_ms, req_box_left, req_box_top, req_box_right,
                              req_box_bottom, req_det_id, req_confidence});
      end
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_result('{rsp_assigned_track, rsp_new_track, rsp_table_full,
                                rsp_activity_level, rsp_sighting_count, rsp_best_score});
      end
   end

   // Receiver: random stalls, optional free running, and long hold-offs on request.
   int stall_mode = 1;
   int hold_asked = 0;
   int hold_taken = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_asked != hold_taken) begin
         hold_taken <= hold_asked;
         hold_left <= 1500;
         rsp_ready <= 1'b0;
      end else if (stall_mode == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0 && stall_mode == 2);
      end
   end

   int burst_left = 0;
   int sent = 0;
   logic [31:0] clock_ms = 0;

   // Offer one item and hold it until accepted; the sender idles between bursts.
   task send_item(box_item_type it);
      req_mode <= it.mode;
      req_time_ms <= it.time_ms;
      req_box_left <= it.left;
      req_box_top <= it.top;
      req_box_right <= it.right;
      req_box_bottom <= it.bottom;
      req_det_id <= it.det_id;
      req_confidence <= it.confidence;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
      end else begin
         burst_left--;
      end
   endtask

   task send_frame(logic [31:0] ms);
      send_item('{1'b0, ms, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom, 16'($urandom)});
   endtask

   task send_box(int l, int t, int r, int b, logic [31:0] sid, logic [15:0] ps);
      send_item('{1'b1, $urandom, 16'(l), 16'(t), 16'(r), 16'(b), sid, ps});
   endtask

   // Wait until every predicted result has come, then let the block settle.
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task load_config(logic [31:0] lost, logic [31:0] extra);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_LOST_TIME;
      csr_wdata <= lost;
      @(posedge clock);
      csr_index <= REG_EXTRA_TIME;
      csr_wdata <= extra;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_config(lost, extra);
   endtask

   function int clamp16(int v);
      return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
   endfunction

   // Objects that move a little from frame to frame, so tracks persist.
   int obj_x[24], obj_y[24], obj_w[24], obj_h[24];
   logic [31:0] obj_sid[24];

   task random_phase(int count, int step_max);
      int k, n, x, y, w, h;
      foreach (obj_x[i]) begin
         obj_x[i] = $urandom_range(0, 60000);
         obj_y[i] = $urandom_range(0, 60000);
         obj_w[i] = $urandom_range(500, 12000);
         obj_h[i] = $urandom_range(500, 12000);
         obj_sid[i] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 40);
      end
      n = 0;
      while (n < count) begin
         // Mostly small time steps; now and then a jump forward or backward.
         case ($urandom_range(0, 9))
            0: clock_ms = $urandom;
            1: clock_ms = clock_ms + $urandom_range(2000, 15000);
            default: clock_ms = clock_ms + $urandom_range(0, step_max);
         endcase
         send_frame(clock_ms);
         n++;
         repeat ($urandom_range(0, 20)) begin
            k = $urandom_range(0, 23);
            case ($urandom_range(0, 9))
               0: send_box($urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
               1: send_box(0, 0, 65535, 65535, obj_sid[k], 16'hFFFF);
               2: send_box($urandom_range(30000, 65535), $urandom_range(30000, 65535),
                           $urandom_range(0, 30000), $urandom_range(0, 30000),
                           obj_sid[k], 16'($urandom));
               default: begin
                  obj_x[k] = clamp16(obj_x[k] + $urandom_range(0, 4000) - 2000);
                  obj_y[k] = clamp16(obj_y[k] + $urandom_range(0, 4000) - 2000);
                  w = clamp16(obj_w[k] + $urandom_range(0, 1000) - 500);
                  h = clamp16(obj_h[k] + $urandom_range(0, 1000) - 500);
                  x = obj_x[k];
                  y = obj_y[k];
                  send_box(x, y, clamp16(x + w), clamp16(y + h),
                           ($urandom_range(0, 5) == 0) ? $urandom : obj_sid[k],
                           16'($urandom));
               end
            endcase
            n++;
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= 1'b0;
      req_time_ms <= '0;
      req_box_left <= '0;
      req_box_top <= '0;
      req_box_right <= '0;
      req_box_bottom <= '0;
      req_det_id <= '0;
      req_confidence <= '0;
      csr_we <= 1'b0;
      csr_index <= REG_LOST_TIME;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with reset settings: extremes, rematch in a frame, ties, expiry.
      send_frame(32'd0);
      send_box(0, 0, 65535, 65535, 32'hFFFF_FFFF, 16'hFFFF);
      send_box(0, 0, 65535, 65535, 32'hFFFF_FFFF, 16'h0000);
      send_box(65535, 65535, 0, 0, 32'd0, 16'd1);
      send_box(0, 0, 0, 0, 32'd7, 16'd2);
      send_box(1000, 1000, 5000, 9000, 32'd9, 16'd100);
      send_box(1000, 1000, 5000, 9000, 32'd10, 16'd200);
      send_frame(32'd100);
      send_box(1000, 1000, 5000, 9000, 32'd11, 16'd300);
      send_box(60000, 60000, 65535, 65535, 32'hFFFF_FFFF, 16'd50);
      send_box(1500, 1200, 5200, 9100, 32'd12, 16'd400);
      send_frame(32'd2100);
      send_box(1000, 1000, 5000, 9000, 32'd9, 16'd5);
      send_frame(32'd2101);
      send_box(1000, 1000, 5000, 9000, 32'd9, 16'd5);
      send_frame(32'hFFFF_FFFF);
      send_box(0, 0, 65535, 65535, 32'hFFFF_FFFF, 16'd1);
      send_frame(32'd5);
      send_box(0, 0, 65535, 65535, 32'hFFFF_FFFF, 16'd1);

      // Sender pauses until every result has come.
      drain();
      random_phase(330, 800);

      // Zero times: only same-frame sightings count, everything expires next frame.
      drain();
      load_config(32'd0, 32'd0);
      stall_mode = 0;
      random_phase(330, 5);

      // Largest times: nothing is ever lost or freed, so the table fills.
      drain();
      load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      stall_mode = 2;
      hold_asked = hold_asked + 1;
      random_phase(330, 3000);

      drain();
      load_config(32'd300, 32'd700);
      stall_mode = 1;
      random_phase(330, 600);

      drain();
      load_config($urandom, $urandom_range(0, 20000));
      hold_asked = hold_asked + 1;
      random_phase(330, 2000);

      drain();
      $display("Sent %0d items over %0d frames and five register settings.", sent,
               tracker.frames);
      $display("Checked %0d results: %0d new tracks, %0d table-full reports.",
               tracker.checked, tracker.opened, tracker.fulls);
      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
